FILE: hdl/lz11_pkg.sv
package lz11_pkg;

	localparam int WINDOW_DEPTH = 4096;
	localparam int WP_W         = $clog2(WINDOW_DEPTH);
	localparam int DIST_W       = WP_W + 1;
	localparam int LEN_W        = 17;
	localparam int SIZE_W       = 24;

	// length bias for the four-byte and three-byte match tokens
	localparam logic [LEN_W-1:0] LEN_LONG_BASE  = LEN_W'(32'hFF + 32'hF + 32'd3);
	localparam logic [LEN_W-1:0] LEN_SHORT_BASE = LEN_W'(32'hF + 32'd2);
	localparam logic [7:0]       FLAG_MSB       = 8'h80;
	localparam logic [3:0]       FLAGS_PER_BYTE = 4'd8;
	localparam logic [3:0]       NIB_LONG       = 4'h1;
	localparam logic [3:0]       NIB_SHORT      = 4'h0;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_REFUSED  = 2'd1;
	localparam logic [1:0] STATUS_BAD_DIST = 2'd2;
	localparam logic [1:0] STATUS_IGNORED  = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_FLAG    = 3'd1,
		PH_ITEM    = 3'd2,
		PH_LEN_MID = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_DIST_LO = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

endpackage

FILE: hdl/lz11_ram.sv
module lz11_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the read word while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/lz11_stream_decompressor_unit.sv
// LZ11 stream decompressor. Feed compressed bytes with mode 0 and pull match
// bytes with mode 1 while copy_pending is high; every accepted word gives
// exactly one result word. A new word is accepted every cycle while in_ready
// is high: the parser state lives in flip-flops and is updated in the cycle
// of acceptance, the history read is issued in that same cycle from the
// 4096-byte single-write, single-read history RAM, and the byte is resolved
// in the next cycle, with the write of the previous byte forwarded so that
// a distance of one runs back to back. The output register then holds it;
// in_ready drops only when both the resolve stage and the output register
// are full and out_ready is low. The history needs no clearing after reset:
// a source before the first output byte is flagged and emits 0.
module lz11_stream_decompressor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] out_byte,
	output logic       copy_pending,
	output logic       end_of_output,
	output logic [1:0] status
);
	import lz11_pkg::*;

	// parser state
	phase_t              phase_q, phase_d;
	logic [1:0]          hcount_q, hcount_d;
	logic [SIZE_W-1:0]   declared_q, declared_d;
	logic [SIZE_W-1:0]   produced_q, produced_d;
	logic [7:0]          flags_q, flags_d;
	logic [3:0]          left_q, left_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [DIST_W-1:0]   dist_q, dist_d;
	logic [LEN_W-1:0]    copy_q, copy_d;
	logic                ended_q, ended_d;
	logic [WP_W-1:0]     wp_q;

	// result of the word being accepted
	logic                res_valid;
	logic [7:0]          res_byte;
	logic                res_ram;
	logic [1:0]          res_status;

	logic                accept;
	logic                adv_s1;
	logic [WP_W-1:0]     rd_addr;
	logic [7:0]          rd_data;
	logic                wr_en;
	logic [7:0]          wr_data;

	// resolve stage
	logic                valid_s1;
	logic                emit_s1;
	logic                ram_s1;
	logic [7:0]          byte_s1;
	logic                fwd_s1;
	logic [7:0]          fwd_data_s1;
	logic [WP_W-1:0]     waddr_s1;
	logic                pend_s1;
	logic                end_s1;
	logic [1:0]          status_s1;

	// output register
	logic                valid_s2;
	logic                bvalid_s2;
	logic [7:0]          byte_s2;
	logic                pend_s2;
	logic                end_s2;
	logic [1:0]          status_s2;

	// the resolve stage moves on whenever the output register is free or drained
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// next parser state
	always_comb begin
		logic [SIZE_W-1:0] room;
		logic              pending;
		phase_d    = phase_q;
		hcount_d   = hcount_q;
		declared_d = declared_q;
		produced_d = produced_q;
		flags_d    = flags_q;
		left_d     = left_q;
		len_d      = len_q;
		dist_d     = dist_q;
		copy_d     = copy_q;
		ended_d    = ended_q;
		room       = declared_q - produced_q;
		pending    = 1'b0;
		if (phase_q == PH_DONE) begin
			phase_d = PH_DONE;
		end else if (mode) begin
			if (copy_q != '0) begin
				produced_d = produced_q + 1'b1;
				copy_d     = copy_q - 1'b1;
				if (copy_d == '0 && (produced_d >= declared_q || ended_q)) begin
					phase_d = PH_DONE;
				end
			end
		end else if (copy_q == '0) begin
			unique case (phase_q)
				PH_HEADER: begin
					unique case (hcount_q)
						2'd1:    declared_d = {16'h0000, in_byte};
						2'd2:    declared_d[15:8] = in_byte;
						2'd3:    declared_d[23:16] = in_byte;
						default: declared_d = declared_q;
					endcase
					if (hcount_q == 2'd3) begin
						produced_d = '0;
						phase_d    = (declared_d == '0) ? PH_DONE : PH_FLAG;
					end
					hcount_d = hcount_q + 1'b1;
				end
				PH_FLAG: begin
					flags_d = in_byte;
					left_d  = FLAGS_PER_BYTE;
					phase_d = PH_ITEM;
				end
				PH_ITEM: begin
					if ((flags_q & FLAG_MSB) == '0) begin
						produced_d = produced_q + 1'b1;
						flags_d    = {flags_q[6:0], 1'b0};
						left_d     = (left_q != '0) ? left_q - 1'b1 : left_q;
						phase_d    = (left_d == '0) ? PH_FLAG : PH_ITEM;
						if (produced_d >= declared_q) begin
							phase_d = PH_DONE;
						end
					end else if (in_byte[7:4] == NIB_LONG) begin
						len_d   = LEN_W'({in_byte[3:0], 12'h000}) + LEN_LONG_BASE;
						phase_d = PH_LEN_MID;
					end else if (in_byte[7:4] == NIB_SHORT) begin
						len_d   = LEN_W'({in_byte[3:0], 4'h0}) + LEN_SHORT_BASE;
						phase_d = PH_LEN_LO;
					end else begin
						len_d   = LEN_W'(in_byte[7:4]) + 1'b1;
						dist_d  = DIST_W'({in_byte[3:0], 8'h00});
						phase_d = PH_DIST_LO;
					end
				end
				PH_LEN_MID: begin
					len_d   = len_q + LEN_W'({in_byte, 4'h0});
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = len_q + LEN_W'(in_byte[7:4]);
					dist_d  = DIST_W'({in_byte[3:0], 8'h00});
					phase_d = PH_DIST_LO;
				end
				PH_DIST_LO: begin
					dist_d  = (dist_q | DIST_W'(in_byte)) + 1'b1;
					copy_d  = (SIZE_W'(len_q) < room) ? len_q : room[LEN_W-1:0];
					pending = copy_d != '0;
					flags_d = {flags_q[6:0], 1'b0};
					left_d  = (left_q != '0) ? left_q - 1'b1 : left_q;
					phase_d = (left_d == '0) ? PH_FLAG : PH_ITEM;
					if (!pending && produced_q >= declared_q) begin
						phase_d = PH_DONE;
					end
				end
				default: phase_d = PH_DONE;
			endcase
			// a final byte ends the stream unless it opened a copy
			if (last_byte) begin
				ended_d = 1'b1;
				if (!pending) begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	// result of the accepted word
	always_comb begin
		res_valid  = 1'b0;
		res_byte   = 8'h00;
		res_ram    = 1'b0;
		res_status = STATUS_OK;
		if (phase_q == PH_DONE) begin
			res_status = STATUS_IGNORED;
		end else if (mode) begin
			if (copy_q == '0) begin
				res_status = STATUS_IGNORED;
			end else begin
				res_valid = 1'b1;
				if (SIZE_W'(dist_q) > produced_q) begin
					res_status = STATUS_BAD_DIST;
				end else begin
					res_ram = 1'b1;
				end
			end
		end else if (copy_q != '0) begin
			res_status = STATUS_REFUSED;
		end else if (phase_q == PH_ITEM && (flags_q & FLAG_MSB) == '0) begin
			res_valid = 1'b1;
			res_byte  = in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hcount_q   <= '0;
			declared_q <= '0;
			produced_q <= '0;
			flags_q    <= '0;
			left_q     <= '0;
			len_q      <= '0;
			dist_q     <= '0;
			copy_q     <= '0;
			ended_q    <= 1'b0;
			wp_q       <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			hcount_q   <= hcount_d;
			declared_q <= declared_d;
			produced_q <= produced_d;
			flags_q    <= flags_d;
			left_q     <= left_d;
			len_q      <= len_d;
			dist_q     <= dist_d;
			copy_q     <= copy_d;
			ended_q    <= ended_d;
			if (res_valid) begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// history: read the copy source at acceptance, write the byte as it resolves
	assign rd_addr = wp_q - dist_q[WP_W-1:0];
	assign wr_data = ram_s1 ? (fwd_s1 ? fwd_data_s1 : rd_data) : byte_s1;
	assign wr_en   = valid_s1 && adv_s1 && emit_s1;

	lz11_ram #(
		.Width (8),
		.Depth (WINDOW_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= res_valid;
			ram_s1      <= res_ram;
			byte_s1     <= res_byte;
			// catch the byte written in this very cycle to the source entry
			fwd_s1      <= wr_en && (waddr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
			waddr_s1    <= wp_q;
			pend_s1     <= copy_d != '0;
			end_s1      <= phase_d == PH_DONE;
			status_s1   <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			bvalid_s2 <= emit_s1;
			byte_s2   <= wr_data;
			pend_s2   <= pend_s1;
			end_s2    <= end_s1;
			status_s2 <= status_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign byte_valid    = bvalid_s2;
	assign out_byte      = byte_s2;
	assign copy_pending  = pend_s2;
	assign end_of_output = end_s2;
	assign status        = status_s2;

endmodule

FILE: hdl/lz11_checker.sv
module lz11_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       mode,
	input logic [7:0] in_byte,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_valid,
	input logic [7:0] out_byte,
	input logic       copy_pending,
	input logic       end_of_output,
	input logic [1:0] status
);
	import lz11_pkg::*;

	logic       done_q;
	logic [1:0] flight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			flight_q <= '0;
		end else begin
			if (out_acc && end_of_output) begin
				done_q <= 1'b1;
			end
			flight_q <= flight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({byte_valid, out_byte,
			copy_pending, end_of_output, status}))
		else $error("result word changed while stalled");

	// once the stream has ended every word is ignored
	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_q |-> end_of_output && !byte_valid && status == STATUS_IGNORED)
		else $error("word not ignored after end of output");

	// never more than two words in flight
	a_flight: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q <= 2'd2 && (flight_q != 2'd0 || !out_valid))
		else $error("input and result words out of step");

	// a source before the first byte gives a zero byte
	a_bad_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_BAD_DIST |-> byte_valid && out_byte == 8'h00)
		else $error("bad distance result carries data");

	// a pending copy keeps the stream open
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && copy_pending |-> !end_of_output)
		else $error("end of output with copy pending");

endmodule

bind lz11_stream_decompressor_unit lz11_checker u_checker (.*);
